// File: rtl/core/slec_pkg.sv
// shared types, codes and command word table for the serial line editor
package slec_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned LineMaxDefault    = 511;
  localparam int unsigned MatchDepthDefault = 12;

  // control characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;

  // result kinds
  localparam logic KindEcho = 1'b0;
  localparam logic KindCmd  = 1'b1;

  // command codes outside the word table
  localparam logic [3:0] CmdEmpty   = 4'd0;
  localparam logic [3:0] CmdUnknown = 4'd9;

  // command word table, bytes in line order, unused tail bytes zero
  localparam int unsigned WordCount  = 8;
  localparam int unsigned WordMaxLen = 11;

  localparam logic [7:0] WordText [WordCount][WordMaxLen] = '{
    '{8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h69, 8'h73, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h69, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h79, 8'h6E, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h72, 8'h69, 8'h6D, 8'h20, 8'h66, 8'h72, 8'h65, 8'h65, 8'h00, 8'h00},
    '{8'h74, 8'h72, 8'h69, 8'h6D, 8'h20, 8'h66, 8'h75, 8'h6C, 8'h6C, 8'h65, 8'h72},
    '{8'h74, 8'h72, 8'h69, 8'h6D, 8'h20, 8'h66, 8'h75, 8'h6C, 8'h6C, 8'h00, 8'h00}
  };

  localparam int unsigned WordLen [WordCount] = '{1, 4, 4, 4, 5, 9, 11, 9};

  localparam logic [3:0] WordCode [WordCount] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8
  };

  // response class of one received byte
  typedef enum logic [1:0] {
    RespChar,
    RespErase,
    RespEol
  } resp_e;

  // decoded response handed from the line stage to the result sequencer
  typedef struct packed {
    resp_e      resp;
    logic [7:0] char_val;
    logic [3:0] cmd_code;
  } desc_t;

endpackage

// File: rtl/core/slec_line.sv
// input register, edit line state and command word match
module slec_line #(
  parameter int unsigned LINE_MAX    = slec_pkg::LineMaxDefault,
  parameter int unsigned MATCH_DEPTH = slec_pkg::MatchDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  output logic            desc_valid_o,
  output slec_pkg::desc_t desc_o,
  input  logic            desc_ready_i
);

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);

  logic                 rx_valid_q;
  logic [7:0]           rx_q;
  logic [LenW-1:0]      len_q;
  logic [LenW-1:0]      len_d;
  logic [7:0]           prefix_q [MATCH_DEPTH];
  logic [31:0]          len_ext;
  logic                 is_eol;
  logic                 is_erase;
  logic                 line_full;
  logic                 line_empty;
  logic                 has_result;
  logic                 consume;
  logic                 store_char;
  logic [slec_pkg::WordCount-1:0] word_hit;
  logic [3:0]           cmd_code;

  assign len_ext    = 32'(len_q);
  assign line_full  = (len_q == LenW'(LINE_MAX));
  assign is_eol     = rx_q inside {slec_pkg::ChCr, slec_pkg::ChLf};
  assign is_erase   = rx_q inside {slec_pkg::ChBs, slec_pkg::ChDel};
  assign line_empty = (len_q == '0) || (prefix_q[0] == slec_pkg::ChNul);

  // byte class and whether it produces any result
  always_comb begin
    if (is_eol) begin
      has_result = 1'b1;
    end else if (is_erase) begin
      has_result = (len_q != '0);
    end else begin
      has_result = !line_full;
    end
  end

  assign consume      = rx_valid_q && (desc_ready_i || !has_result);
  assign in_ready_o   = !rx_valid_q || consume;
  assign desc_valid_o = rx_valid_q && has_result;
  assign store_char   = consume && !is_eol && !is_erase && !line_full;

  // word match: exact bytes, then end of line or a stored nul right after
  always_comb begin
    for (int w = 0; w < slec_pkg::WordCount; w++) begin
      word_hit[w] = (len_ext == slec_pkg::WordLen[w]) ||
                    ((len_ext > slec_pkg::WordLen[w]) &&
                     (prefix_q[slec_pkg::WordLen[w]] == slec_pkg::ChNul));
      for (int i = 0; i < slec_pkg::WordMaxLen; i++) begin
        if ((i < slec_pkg::WordLen[w]) && (prefix_q[i] != slec_pkg::WordText[w][i])) begin
          word_hit[w] = 1'b0;
        end
      end
    end
  end

  // command code selection
  always_comb begin
    cmd_code = slec_pkg::CmdUnknown;
    for (int w = 0; w < slec_pkg::WordCount; w++) begin
      if (word_hit[w]) begin
        cmd_code = slec_pkg::WordCode[w];
      end
    end
    if (line_empty) begin
      cmd_code = slec_pkg::CmdEmpty;
    end
  end

  // descriptor for the result sequencer
  always_comb begin
    desc_o.char_val = rx_q;
    desc_o.cmd_code = cmd_code;
    if (is_eol) begin
      desc_o.resp = slec_pkg::RespEol;
    end else if (is_erase) begin
      desc_o.resp = slec_pkg::RespErase;
    end else begin
      desc_o.resp = slec_pkg::RespChar;
    end
  end

  // next line length
  always_comb begin
    len_d = len_q;
    if (consume) begin
      if (is_eol) begin
        len_d = '0;
      end else if (is_erase) begin
        if (len_q != '0) begin
          len_d = len_q - LenW'(1);
        end
      end else if (!line_full) begin
        len_d = len_q + LenW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
      len_q      <= '0;
    end else begin
      len_q <= len_d;
      if (in_valid_i && in_ready_o) begin
        rx_valid_q <= 1'b1;
      end else if (consume) begin
        rx_valid_q <= 1'b0;
      end
    end
  end

  // input byte register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_q <= rx_byte_i;
    end
  end

  // kept line prefix, written at the current length
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MATCH_DEPTH; i++) begin
      if (store_char && (len_ext == i)) begin
        prefix_q[i] <= rx_q;
      end
    end
  end

endmodule

// File: rtl/core/slec_emit.sv
// result sequencer: holds one response and issues its result transfers
module slec_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  slec_pkg::desc_t desc_i,
  output logic            desc_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output logic [7:0]      echo_byte_o,
  output logic [3:0]      command_o,
  output logic            last_o
);

  localparam logic [1:0] StepFirst = 2'd0;
  localparam logic [1:0] StepMid   = 2'd1;
  localparam logic [1:0] StepLast  = 2'd2;

  slec_pkg::desc_t desc_q;
  logic            busy_q;
  logic [1:0]      step_q;
  logic            out_xfer;

  assign out_valid_o  = busy_q;
  assign out_xfer     = busy_q && out_ready_i;
  assign desc_ready_o = !busy_q || (out_xfer && last_o);

  // result fields for the current step
  always_comb begin
    kind_o      = slec_pkg::KindEcho;
    echo_byte_o = slec_pkg::ChNul;
    command_o   = slec_pkg::CmdEmpty;
    last_o      = 1'b1;
    case (desc_q.resp)
      slec_pkg::RespChar: begin
        echo_byte_o = desc_q.char_val;
      end
      slec_pkg::RespErase: begin
        echo_byte_o = (step_q == StepMid) ? slec_pkg::ChSpace : slec_pkg::ChBs;
        last_o      = (step_q == StepLast);
      end
      slec_pkg::RespEol: begin
        last_o = (step_q == StepLast);
        if (step_q == StepFirst) begin
          echo_byte_o = slec_pkg::ChCr;
        end else if (step_q == StepMid) begin
          echo_byte_o = slec_pkg::ChLf;
        end else begin
          kind_o    = slec_pkg::KindCmd;
          command_o = desc_q.cmd_code;
        end
      end
      default: begin
        last_o = 1'b1;
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepFirst;
    end else begin
      if (desc_valid_i && desc_ready_o) begin
        busy_q <= 1'b1;
        step_q <= StepFirst;
      end else if (out_xfer) begin
        if (last_o) begin
          busy_q <= 1'b0;
          step_q <= StepFirst;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (desc_valid_i && desc_ready_o) begin
      desc_q <= desc_i;
    end
  end

endmodule

// File: rtl/core/serial_line_editor_command_decoder_unit.sv
// top level of the serial line editor with command word decoder
// the line stage, then the sequencer, register a byte before its first result is given
// throughput: one byte per cycle for plain echoes unless the result port stalls; erase
//   and line end give three results each through the sequencer's single result port
// bytes with no result (full line, erase on empty line) need not wait for the sequencer
// reset clears the line length and empties both stages; kept line bytes are not cleared
module serial_line_editor_command_decoder_unit #(
  parameter int unsigned LINE_MAX    = slec_pkg::LineMaxDefault,
  parameter int unsigned MATCH_DEPTH = slec_pkg::MatchDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] echo_byte_o,
  output logic [3:0] command_o,
  output logic       last_o
);

  logic            desc_valid;
  logic            desc_ready;
  slec_pkg::desc_t desc;

  // line state and decode
  slec_line #(
    .LINE_MAX   (LINE_MAX),
    .MATCH_DEPTH(MATCH_DEPTH)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .desc_valid_o(desc_valid),
    .desc_o      (desc),
    .desc_ready_i(desc_ready)
  );

  // result sequencing
  slec_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_valid_i(desc_valid),
    .desc_i      (desc),
    .desc_ready_o(desc_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .echo_byte_o (echo_byte_o),
    .command_o   (command_o),
    .last_o      (last_o)
  );

  // a command result always closes its byte and carries no echo byte
  a_cmd_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == slec_pkg::KindCmd) |-> last_o && (echo_byte_o == 8'h00))
    else $error("command result not last or with echo byte");

  // echo results carry no command code
  a_echo_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == slec_pkg::KindEcho) |-> (command_o == slec_pkg::CmdEmpty))
    else $error("echo result with command code");

  // a transfer that is not last is followed by another pending result
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("result sequence cut short");

  // the decoded response is never dropped while the sequencer is busy
  a_desc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid && !desc_ready |=> desc_valid && $stable(desc))
    else $error("decoded response lost");

endmodule

// File: tb/serial_line_editor_command_decoder_checker.sv
// checker for the line editor: predicts echo and command results and compares transfers
`timescale 1ns / 100ps
module serial_line_editor_command_decoder_checker #(
  parameter int unsigned LINE_MAX    = slec_pkg::LineMaxDefault,
  parameter int unsigned MATCH_DEPTH = slec_pkg::MatchDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       kind_i,
  input  logic [7:0] echo_byte_i,
  input  logic [3:0] command_i,
  input  logic       last_i,
  output int         pending_o,
  output int         fail_count_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);

  // command codes as the decoder reports them
  typedef enum logic [3:0] {
    CodeEmpty,
    CodeHelp,
    CodeDisk,
    CodeInit,
    CodeSync,
    CodeReset,
    CodeTrimFree,
    CodeTrimFuller,
    CodeTrimFull,
    CodeUnknown
  } cmd_code_e;

  // one item on the transmit side
  typedef struct packed {
    logic       kind;
    logic [7:0] echo_byte;
    logic [3:0] command;
    logic       last;
  } tx_item_t;

  tx_item_t        tx_expected_q[$];
  logic [LenW-1:0] line_len;
  logic [7:0]      line_head [MATCH_DEPTH];
  int              mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  // spelling of each command word
  function automatic string word_text(input cmd_code_e code);
    case (code)
      CodeHelp:       return "?";
      CodeDisk:       return "disk";
      CodeInit:       return "init";
      CodeSync:       return "sync";
      CodeReset:      return "reset";
      CodeTrimFree:   return "trim free";
      CodeTrimFuller: return "trim fuller";
      CodeTrimFull:   return "trim full";
      default:        return "";
    endcase
  endfunction

  function automatic tx_item_t make_item(input logic kind, input logic [7:0] echo_byte,
                                         input logic [3:0] command, input logic last);
    tx_item_t item;
    item.kind      = kind;
    item.echo_byte = echo_byte;
    item.command   = command;
    item.last      = last;
    return item;
  endfunction

  // command code of the line as it stands
  function automatic logic [3:0] decode_command();
    int unsigned kept;
    int unsigned used;
    int unsigned c;
    int unsigned j;
    bit          bounded;
    bit          found;
    bit          hit;
    string       text;
    logic [3:0]  code;
    kept    = (line_len < MATCH_DEPTH) ? line_len : MATCH_DEPTH;
    used    = kept;
    bounded = (line_len <= MATCH_DEPTH);
    found   = 1'b0;
    code    = CodeUnknown;
    if (line_len == 0 || line_head[0] == slec_pkg::ChNul) return CodeEmpty;
    // matching stops at the first stored nul
    for (j = 0; j < kept; j++) begin
      if (!found && line_head[j] == slec_pkg::ChNul) begin
        used  = j;
        found = 1'b1;
      end
    end
    // a long line with no nul among the kept bytes can match nothing
    if (!(bounded || found)) return CodeUnknown;
    for (c = CodeHelp; c <= CodeTrimFull; c++) begin
      text = word_text(cmd_code_e'(c));
      if (text.len() == used) begin
        hit = 1'b1;
        for (j = 0; j < used; j++) begin
          if (line_head[j] != text.getc(j)) hit = 1'b0;
        end
        if (hit) code = 4'(c);
      end
    end
    return code;
  endfunction

  // update the line with one received byte and queue what it should transmit
  task automatic apply_rx_byte(input logic [7:0] rx);
    if (rx == slec_pkg::ChCr || rx == slec_pkg::ChLf) begin
      tx_expected_q.push_back(make_item(slec_pkg::KindEcho, slec_pkg::ChCr, CodeEmpty, 1'b0));
      tx_expected_q.push_back(make_item(slec_pkg::KindEcho, slec_pkg::ChLf, CodeEmpty, 1'b0));
      tx_expected_q.push_back(make_item(slec_pkg::KindCmd, slec_pkg::ChNul,
                                        decode_command(), 1'b1));
      line_len = '0;
    end else if (rx == slec_pkg::ChBs || rx == slec_pkg::ChDel) begin
      // erase on an empty line is silent
      if (line_len != 0) begin
        line_len = line_len - 1'b1;
        tx_expected_q.push_back(make_item(slec_pkg::KindEcho, slec_pkg::ChBs, CodeEmpty, 1'b0));
        tx_expected_q.push_back(make_item(slec_pkg::KindEcho, slec_pkg::ChSpace, CodeEmpty,
                                          1'b0));
        tx_expected_q.push_back(make_item(slec_pkg::KindEcho, slec_pkg::ChBs, CodeEmpty, 1'b1));
      end
    end else if (line_len < LINE_MAX) begin
      // bytes past a full line are dropped without echo
      if (line_len < MATCH_DEPTH) line_head[line_len] = rx;
      line_len = line_len + 1'b1;
      tx_expected_q.push_back(make_item(slec_pkg::KindEcho, rx, CodeEmpty, 1'b1));
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: line editor mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  // watch both channels, results first since they trail their input by cycles
  always @(posedge clk_i or negedge rst_ni) begin
    tx_item_t want;
    if (!rst_ni) begin
      line_len = '0;
      tx_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tx_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer kind %0d echo %h cmd %0d last %0d",
                                    kind_i, echo_byte_i, command_i, last_i));
        end else begin
          want = tx_expected_q.pop_front();
          if (kind_i !== want.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", kind_i, want.kind));
          if (echo_byte_i !== want.echo_byte)
            report_mismatch($sformatf("echo_byte %h, wanted %h", echo_byte_i, want.echo_byte));
          if (command_i !== want.command)
            report_mismatch($sformatf("command %0d, wanted %0d", command_i, want.command));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %0d, wanted %0d", last_i, want.last));
        end
      end
      if (in_valid_i && in_ready_i) apply_rx_byte(rx_byte_i);
      pending_o <= tx_expected_q.size();
    end
  end

endmodule

// File: tb/tb_serial_line_editor_command_decoder_unit.sv
// testbench top: feeds received bytes to the line editor and gives the verdict
`timescale 1ns / 100ps
module tb_serial_line_editor_command_decoder_unit;

  localparam int unsigned LineMax       = slec_pkg::LineMaxDefault;
  localparam int unsigned RandomBytes   = 400;
  localparam int unsigned PhaseBytes    = 100;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 20;

  // shapes of a command line in the random part
  typedef enum int unsigned {
    LineExact,
    LineBitFlip,
    LineCut,
    LineRetype,
    LineTail,
    LineNulTail
  } line_shape_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       kind_o;
  logic [7:0] echo_byte_o;
  logic [3:0] command_o;
  logic       last_o;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          pending;
  int          fail_count;
  int unsigned quiet_cycles   = 0;
  int unsigned bytes_sent     = 0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  serial_line_editor_command_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .echo_byte_o (echo_byte_o),
    .command_o   (command_o),
    .last_o      (last_o)
  );

  serial_line_editor_command_decoder_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_i       (kind_o),
    .echo_byte_i  (echo_byte_o),
    .command_i    (command_o),
    .last_i       (last_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // transmit side stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int unsigned j;
    for (j = 0; j < s.len(); j++) send_byte(s.getc(j));
  endtask

  // hold the sender until every expected result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_eol();
    send_byte($urandom_range(1) ? slec_pkg::ChCr : slec_pkg::ChLf);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == slec_pkg::ChCr || b == slec_pkg::ChLf ||
           b == slec_pkg::ChBs || b == slec_pkg::ChDel);
    return b;
  endfunction

  function automatic logic [7:0] erase_byte();
    return $urandom_range(1) ? slec_pkg::ChBs : slec_pkg::ChDel;
  endfunction

  // shortest line that overruns the kept bytes
  function automatic int unsigned MatchDepthLong();
    return slec_pkg::MatchDepthDefault + 1;
  endfunction

  // a command word, exact or slightly broken, closed by a line end
  task automatic send_command_line();
    int unsigned w;
    int unsigned len;
    int unsigned pos;
    int unsigned j;
    line_shape_e shape;
    logic [7:0]  text [slec_pkg::WordMaxLen];
    w   = $urandom_range(slec_pkg::WordCount - 1);
    len = slec_pkg::WordLen[w];
    for (j = 0; j < len; j++) text[j] = slec_pkg::WordText[w][j];
    pos   = $urandom_range(len - 1);
    shape = $urandom_range(1) ? LineExact : line_shape_e'($urandom_range(LineNulTail));
    if (shape == LineBitFlip) text[pos] = text[pos] ^ (8'h01 << $urandom_range(7));
    if (shape == LineCut) len = pos;
    for (j = 0; j < len; j++) begin
      send_byte(text[j]);
      if (shape == LineRetype && j == pos) begin
        send_byte(erase_byte());
        send_byte(text[j]);
      end
    end
    if (shape == LineTail) send_byte(plain_byte());
    // bytes after a nul do not take part in the match
    if (shape == LineNulTail) begin
      send_byte(slec_pkg::ChNul);
      repeat ($urandom_range(15)) send_byte(plain_byte());
    end
    send_eol();
  endtask

  // a line of random bytes, short or past the match depth
  task automatic send_random_line(input int unsigned min_len, input int unsigned max_len);
    repeat ($urandom_range(max_len, min_len)) begin
      send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : plain_byte());
    end
    send_eol();
  endtask

  initial begin
    int unsigned start;
    int unsigned phase;
    int unsigned pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: erase on an empty line, empty and nul-led lines, extremes of the byte
    send_byte(slec_pkg::ChBs);
    send_byte(slec_pkg::ChDel);
    send_byte(slec_pkg::ChCr);
    send_byte(8'hFF);
    send_byte(slec_pkg::ChDel);
    send_byte(slec_pkg::ChNul);
    send_byte(slec_pkg::ChLf);
    send_text("?");
    send_byte(slec_pkg::ChNul);
    send_text("x");
    send_byte(slec_pkg::ChCr);
    send_text("syncq");
    send_byte(slec_pkg::ChBs);
    send_byte(slec_pkg::ChLf);
    send_text("resets");
    send_byte(slec_pkg::ChCr);
    drain_results();

    // fill the line past its end, then erase one and overflow again
    repeat (LineMax + 3) send_byte(plain_byte());
    send_byte(slec_pkg::ChDel);
    send_byte(plain_byte());
    send_byte(plain_byte());
    send_byte(slec_pkg::ChCr);
    drain_results();

    // random part in phases of idling on either side
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RandomBytes) begin
      if ((bytes_sent - start) / PhaseBytes != phase) begin
        phase = (bytes_sent - start) / PhaseBytes;
        drain_results();
        send_idle_pct  <= (phase == 1) ? 53 : (phase == 3) ? 30 : 0;
        recv_stall_pct <= (phase == 2) ? 53 : (phase == 3) ? 30 : 0;
        @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_command_line();
      end else if (pick < 70) begin
        send_random_line(0, 11);
      end else if (pick < 80) begin
        send_random_line(MatchDepthLong(), 30);
      end else if (pick < 90) begin
        repeat ($urandom_range(15, 1)) send_byte(erase_byte());
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/slec_pkg.sv
rtl/core/slec_line.sv
rtl/core/slec_emit.sv
rtl/core/serial_line_editor_command_decoder_unit.sv
tb/serial_line_editor_command_decoder_checker.sv
tb/tb_serial_line_editor_command_decoder_unit.sv
